// ===== rtl/cwsm_pkg.sv =====
package cwsm_pkg;

  // Field widths of the command and result beats.
  localparam int VEL_W  = 18;
  localparam int ANG_W  = 16;
  localparam int WHL_W  = 20;
  localparam int RATE_W = 17;
  localparam int GAIN_W = 18;

  // Velocity width after the heading rotation, and the rotation datapath width.
  localparam int EXT_W = 20;
  localparam int CW    = 34;

  localparam int CORDIC_STAGES = 16;

  localparam logic [RATE_W-1:0] RATE_ONE   = 17'd65536;
  localparam logic [RATE_W-1:0] RATE_RESET = 17'd32768;
  localparam logic [GAIN_W-1:0] GAIN_ONE   = 18'd65536;

  localparam logic signed [17:0] SQRT3_HALF_Q16 = 18'sd56756;
  localparam logic signed [CW-1:0] CORDIC_K_Q30 = 34'sd652032874;

  localparam logic signed [23:0] WHEEL_MAX = 24'sd524287;
  localparam logic signed [23:0] WHEEL_MIN = -24'sd524288;

  // Arctangent of 2^-i as a 32-bit binary angle.
  localparam logic [31:0] ATAN_TAB [24] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
    32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163, 32'd81
  };

  // Configuration register indexes.
  localparam logic REG_WIDTH_RATE  = 1'b0;
  localparam logic REG_LENGTH_RATE = 1'b1;

  typedef enum logic [2:0] {
    OP_TWO     = 3'd0,
    OP_THREE   = 3'd1,
    OP_SKID    = 3'd2,
    OP_MECANUM = 3'd3,
    OP_OFFCTR  = 3'd4,
    OP_CAR     = 3'd5
  } op_t;

  typedef struct packed {
    op_t                     op;
    logic                    headless;
    logic signed [VEL_W-1:0] vx;
    logic signed [VEL_W-1:0] vy;
    logic signed [VEL_W-1:0] vw;
    logic signed [ANG_W-1:0] heading;
  } item_t;

  typedef logic [3:0][GAIN_W-1:0] gain_set_t;

  typedef struct packed {
    logic signed [WHL_W-1:0] wheel_a;
    logic signed [WHL_W-1:0] wheel_b;
    logic signed [WHL_W-1:0] wheel_c;
    logic signed [WHL_W-1:0] wheel_d;
    logic [2:0]              active_wheels;
    logic signed [ANG_W-1:0] steer_angle;
    logic                    saturated;
  } res_t;

endpackage

// ===== rtl/cwsm_gain.sv =====
module cwsm_gain import cwsm_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [RATE_W-1:0] cfg_wdata,
  output gain_set_t         gains
);

  localparam int SQRT_CYC = GAIN_W / 2;

  logic [RATE_W-1:0] width_r, length_r, wr_clamp;
  logic              load_r;
  logic [3:0]        cnt_r;
  logic [35:0]       rad_r  [4];
  logic [21:0]       rem_r  [4];
  logic [GAIN_W-1:0] root_r [4];
  logic [35:0]       rad_ld [4];
  logic [35:0]       rad_nxt  [4];
  logic [21:0]       rem_nxt  [4];
  logic [GAIN_W-1:0] root_nxt [4];
  gain_set_t         gains_r;

  // Rates above one are held at one.
  assign wr_clamp = (cfg_wdata > RATE_ONE) ? RATE_ONE : cfg_wdata;

  // Radicands 4*w*l for the four corners: LF, LR, RF, RR.
  always_comb begin
    logic [RATE_W-1:0] wn, ln;
    wn = RATE_ONE - width_r;
    ln = RATE_ONE - length_r;
    rad_ld[0] = {34'(width_r * length_r), 2'b00};
    rad_ld[1] = {34'(width_r * ln), 2'b00};
    rad_ld[2] = {34'(wn * length_r), 2'b00};
    rad_ld[3] = {34'(wn * ln), 2'b00};
  end

  // Two digit-by-digit square root steps per cycle for each corner.
  always_comb begin
    logic [21:0]       r;
    logic [21:0]       trial;
    logic [GAIN_W-1:0] q;
    logic [35:0]       n;
    for (int u = 0; u < 4; u++) begin
      r = rem_r[u];
      q = root_r[u];
      n = rad_r[u];
      for (int s = 0; s < 2; s++) begin
        r = {r[19:0], n[35:34]};
        n = {n[33:0], 2'b00};
        trial = {2'b00, q, 2'b01};
        if (r >= trial) begin
          r = r - trial;
          q = {q[GAIN_W-2:0], 1'b1};
        end else begin
          q = {q[GAIN_W-2:0], 1'b0};
        end
      end
      rem_nxt[u]  = r;
      root_nxt[u] = q;
      rad_nxt[u]  = n;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= RATE_RESET;
      length_r <= RATE_RESET;
      load_r   <= 1'b0;
      cnt_r    <= '0;
      gains_r  <= {4{GAIN_ONE}};
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_WIDTH_RATE:  width_r  <= wr_clamp;
          REG_LENGTH_RATE: length_r <= wr_clamp;
          default: ;
        endcase
      end
      load_r <= cfg_we;
      if (load_r) begin
        cnt_r <= 4'(SQRT_CYC);
        for (int u = 0; u < 4; u++) begin
          rad_r[u]  <= rad_ld[u];
          rem_r[u]  <= '0;
          root_r[u] <= '0;
        end
      end else if (cnt_r != '0) begin
        cnt_r <= cnt_r - 4'd1;
        for (int u = 0; u < 4; u++) begin
          rad_r[u]  <= rad_nxt[u];
          rem_r[u]  <= rem_nxt[u];
          root_r[u] <= root_nxt[u];
          if (cnt_r == 4'd1) begin
            gains_r[u] <= root_nxt[u];
          end
        end
      end
    end
  end

  assign gains = gains_r;

endmodule

// ===== rtl/cwsm_cordic.sv =====
module cwsm_cordic import cwsm_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 in_valid,
  input  item_t                in_item,
  output logic                 out_valid,
  output item_t                out_item,
  output logic signed [CW-1:0] out_x,
  output logic signed [CW-1:0] out_y,
  output logic                 out_neg
);

  localparam logic signed [CW-1:0] ZLIM  = 34'sd1073741824;
  localparam logic signed [CW-1:0] ZWRAP = 34'sd2147483648;

  logic signed [CW-1:0] x_r [CORDIC_STAGES+1];
  logic signed [CW-1:0] y_r [CORDIC_STAGES+1];
  logic signed [CW-1:0] z_r [CORDIC_STAGES+1];
  logic                 neg_r [CORDIC_STAGES+1];
  logic                 vld_r [CORDIC_STAGES+1];
  item_t                itm_r [CORDIC_STAGES+1];

  logic signed [CW-1:0] z_in, z_fold;
  logic                 neg_in;

  // Fold the angle into the right half plane and remember the sign flip.
  always_comb begin
    z_in   = {{2{in_item.heading[ANG_W-1]}}, in_item.heading, 16'b0};
    z_fold = z_in;
    neg_in = 1'b0;
    if (z_in > ZLIM) begin
      z_fold = z_in - ZWRAP;
      neg_in = 1'b1;
    end else if (z_in < -ZLIM) begin
      z_fold = z_in + ZWRAP;
      neg_in = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= in_valid;
    end
    if (en) begin
      x_r[0]   <= CORDIC_K_Q30;
      y_r[0]   <= '0;
      z_r[0]   <= z_fold;
      neg_r[0] <= neg_in;
      itm_r[0] <= in_item;
    end
  end

  // One micro-rotation per register stage.
  for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_stage
    logic signed [CW-1:0] atan_k;
    assign atan_k = $signed({2'b00, ATAN_TAB[k]});

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k+1] <= 1'b0;
      end else if (en) begin
        vld_r[k+1] <= vld_r[k];
      end
      if (en) begin
        if (z_r[k] >= 0) begin
          x_r[k+1] <= x_r[k] - (y_r[k] >>> k);
          y_r[k+1] <= y_r[k] + (x_r[k] >>> k);
          z_r[k+1] <= z_r[k] - atan_k;
        end else begin
          x_r[k+1] <= x_r[k] + (y_r[k] >>> k);
          y_r[k+1] <= y_r[k] - (x_r[k] >>> k);
          z_r[k+1] <= z_r[k] + atan_k;
        end
        neg_r[k+1] <= neg_r[k];
        itm_r[k+1] <= itm_r[k];
      end
    end
  end

  assign out_valid = vld_r[CORDIC_STAGES];
  assign out_item  = itm_r[CORDIC_STAGES];
  assign out_x     = x_r[CORDIC_STAGES];
  assign out_y     = y_r[CORDIC_STAGES];
  assign out_neg   = neg_r[CORDIC_STAGES];

endmodule

// ===== rtl/cwsm_mix.sv =====
module cwsm_mix import cwsm_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 in_valid,
  input  item_t                in_item,
  input  logic signed [CW-1:0] cos_x,
  input  logic signed [CW-1:0] sin_y,
  input  logic                 neg,
  input  gain_set_t            gains,
  output logic                 out_valid,
  output res_t                 out_res
);

  // Stage 1: rotation products.
  logic                 v1_r;
  item_t                i1_r;
  logic                 n1_r;
  logic signed [51:0]   p_xc_r, p_ys_r, p_yc_r, p_xs_r;

  // Stage 2: rotated velocities.
  logic                    v2_r;
  op_t                     op2_r;
  logic signed [EXT_W-1:0] vx2_r, vy2_r;
  logic signed [VEL_W-1:0] vw2_r;
  logic signed [ANG_W-1:0] hd2_r;

  // Stage 3: three-wheel and yaw gain products.
  logic                    v3_r;
  op_t                     op3_r;
  logic signed [EXT_W-1:0] vx3_r, vy3_r;
  logic signed [VEL_W-1:0] vw3_r;
  logic signed [ANG_W-1:0] hd3_r;
  logic signed [37:0]      tp_r;
  logic signed [36:0]      yp_r [4];

  // Stage 4: result register.
  logic v4_r;
  res_t res_r;

  logic signed [EXT_W-1:0] vx_sel, vy_sel;
  logic signed [37:0]      tp_nxt;
  logic signed [36:0]      yp_nxt [4];
  res_t                    res_nxt;

  always_ff @(posedge clk) begin
    if (en) begin
      p_xc_r <= 52'(in_item.vx * cos_x);
      p_ys_r <= 52'(in_item.vy * sin_y);
      p_yc_r <= 52'(in_item.vy * cos_x);
      p_xs_r <= 52'(in_item.vx * sin_y);
      i1_r   <= in_item;
      n1_r   <= neg;
    end
  end

  // Sum, undo the fold, round from Q30; only headless modes 1 and 3 rotate.
  always_comb begin
    logic signed [53:0] sx, sy;
    logic               rot;
    sx = 54'(p_xc_r) + 54'(p_ys_r);
    sy = 54'(p_yc_r) - 54'(p_xs_r);
    if (n1_r) begin
      sx = -sx;
      sy = -sy;
    end
    sx = (sx + 54'sd536870912) >>> 30;
    sy = (sy + 54'sd536870912) >>> 30;
    rot = i1_r.headless && (i1_r.op == OP_THREE || i1_r.op == OP_MECANUM);
    vx_sel = rot ? sx[EXT_W-1:0] : EXT_W'(i1_r.vx);
    vy_sel = rot ? sy[EXT_W-1:0] : EXT_W'(i1_r.vy);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      op2_r <= i1_r.op;
      vx2_r <= vx_sel;
      vy2_r <= vy_sel;
      vw2_r <= i1_r.vw;
      hd2_r <= i1_r.heading;
    end
  end

  always_comb begin
    tp_nxt = (38'(vy2_r) <<< 15) - 38'(vx2_r * SQRT3_HALF_Q16);
    for (int k = 0; k < 4; k++) begin
      yp_nxt[k] = 37'(vw2_r * $signed({1'b0, gains[k]}));
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      op3_r <= op2_r;
      vx3_r <= vx2_r;
      vy3_r <= vy2_r;
      vw3_r <= vw2_r;
      hd3_r <= hd2_r;
      tp_r  <= tp_nxt;
      for (int k = 0; k < 4; k++) begin
        yp_r[k] <= yp_nxt[k];
      end
    end
  end

  // Wheel mixing per drive arrangement, then clipping to the output range.
  always_comb begin
    logic signed [23:0] x, y, w, t;
    logic signed [23:0] yw [4];
    logic signed [37:0] tr;
    logic signed [36:0] yr;
    logic signed [23:0] wh [4];
    logic               sat;
    x  = 24'(vx3_r);
    y  = 24'(vy3_r);
    w  = 24'(vw3_r);
    tr = (tp_r + 38'sd32768) >>> 16;
    t  = tr[23:0];
    for (int k = 0; k < 4; k++) begin
      yr    = (yp_r[k] + 37'sd32768) >>> 16;
      yw[k] = yr[23:0];
      wh[k] = '0;
    end
    res_nxt = '0;
    case (op3_r)
      OP_TWO: begin
        wh[0] = w - x;
        wh[1] = x + w;
        res_nxt.active_wheels = 3'd2;
      end
      OP_THREE: begin
        wh[0] = y + w;
        wh[1] = w - t;
        wh[2] = w + t;
        res_nxt.active_wheels = 3'd3;
      end
      OP_SKID: begin
        wh[0] = w - x;
        wh[1] = w - x;
        wh[2] = x + w;
        wh[3] = x + w;
        res_nxt.active_wheels = 3'd4;
      end
      OP_MECANUM: begin
        wh[0] = y + x + w;
        wh[1] = -y + x + w;
        wh[2] = y - x + w;
        wh[3] = -y - x + w;
        res_nxt.active_wheels = 3'd4;
      end
      OP_OFFCTR: begin
        wh[0] = y + x + yw[0];
        wh[1] = -y + x + yw[1];
        wh[2] = y - x + yw[2];
        wh[3] = -y - x + yw[3];
        res_nxt.active_wheels = 3'd4;
      end
      OP_CAR: begin
        wh[0] = x;
        res_nxt.steer_angle   = hd3_r;
        res_nxt.active_wheels = 3'd1;
      end
      default: ;
    endcase
    sat = 1'b0;
    for (int k = 0; k < 4; k++) begin
      if (wh[k] > WHEEL_MAX) begin
        wh[k] = WHEEL_MAX;
        sat   = 1'b1;
      end else if (wh[k] < WHEEL_MIN) begin
        wh[k] = WHEEL_MIN;
        sat   = 1'b1;
      end
    end
    res_nxt.wheel_a   = wh[0][WHL_W-1:0];
    res_nxt.wheel_b   = wh[1][WHL_W-1:0];
    res_nxt.wheel_c   = wh[2][WHL_W-1:0];
    res_nxt.wheel_d   = wh[3][WHL_W-1:0];
    res_nxt.saturated = sat;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_r <= res_nxt;
    end
  end

  // Valid bits travel alongside the data.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  assign out_valid = v4_r;
  assign out_res   = res_r;

endmodule

// ===== rtl/chassis_wheel_speed_mixer.sv =====
// Chassis wheel speed mixer.
// The slave channel takes one body velocity command per beat (vx, vy, yaw rate,
// heading, drive mode); the master channel returns one beat of wheel speed
// setpoints for each command, in the same order.
// The configuration port writes the width share of the rotation centre (index 0)
// and its length share (index 1); after a write the four off-centre yaw gains are
// recomputed by square root units and settle well before a command accepted right
// after the write reaches the gain multipliers.
// Each command passes one angle fold stage, one stage per CORDIC iteration
// (CORDIC_STAGES, 16 by default), then four stages of products, rotation,
// gain products and mixing, before its result can be taken.
// Throughput is one command per cycle in every mode, unless a result stalls.
// Reset clears all pipeline valid bits, sets both rates to one half and all
// yaw gains to one.
// When the receiver holds out_tready low with a result waiting, the whole
// pipeline freezes and in_tready drops in the same cycle; nothing is lost.
module chassis_wheel_speed_mixer import cwsm_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  // vel_x[17:0], vel_y[35:18], vel_yaw[53:36], heading[69:54], zero pad
  input  logic [71:0]       in_tdata,
  // operation[2:0], headless[3], bit 4 unused
  input  logic [4:0]        in_tuser,
  output logic              out_tvalid,
  input  logic              out_tready,
  // wheel_a[19:0], wheel_b[39:20], wheel_c[59:40], wheel_d[79:60], steer_angle[95:80]
  output logic [95:0]       out_tdata,
  // active_wheels[2:0], saturated[3]
  output logic [3:0]        out_tuser,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [RATE_W-1:0] cfg_wdata
);

  logic                 en;
  item_t                in_item;
  logic                 c_valid, c_neg;
  item_t                c_item;
  logic signed [CW-1:0] c_x, c_y;
  gain_set_t            gains;
  res_t                 res;

  // The pipeline advances unless a finished result is waiting.
  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;

  always_comb begin
    in_item.op       = op_t'(in_tuser[2:0]);
    in_item.headless = in_tuser[3];
    in_item.vx       = in_tdata[17:0];
    in_item.vy       = in_tdata[35:18];
    in_item.vw       = in_tdata[53:36];
    in_item.heading  = in_tdata[69:54];
  end

  cwsm_gain u_gain (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .gains     (gains)
  );

  cwsm_cordic u_cordic (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (in_tvalid),
    .in_item   (in_item),
    .out_valid (c_valid),
    .out_item  (c_item),
    .out_x     (c_x),
    .out_y     (c_y),
    .out_neg   (c_neg)
  );

  cwsm_mix u_mix (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (c_valid),
    .in_item   (c_item),
    .cos_x     (c_x),
    .sin_y     (c_y),
    .neg       (c_neg),
    .gains     (gains),
    .out_valid (out_tvalid),
    .out_res   (res)
  );

  assign out_tdata = {res.steer_angle, res.wheel_d, res.wheel_c, res.wheel_b, res.wheel_a};
  assign out_tuser = {res.saturated, res.active_wheels};

  // Nothing is presented in the cycle after reset.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  // The fourth wheel is only driven in the four-wheel modes.
  a_wheel_d_unused: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[2:0] != 3'd4 |-> out_tdata[79:60] == '0)
    else $error("wheel_d driven outside a four-wheel mode");

  // A steer angle only appears in car mode.
  a_steer_car_only: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[95:80] != '0 |-> out_tuser[2:0] == 3'd1)
    else $error("steer angle outside car mode");

  // A waiting result freezes the input side.
  a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |-> !in_tready)
    else $error("input accepted while the result stalls");

endmodule
